/* rtl/core/euclidean_distance_matrix_table_top_assert.svh */
// assertion macros for the distance matrix table top level
// depends on nothing; included by the top level only
`ifndef EUCLIDEAN_DISTANCE_MATRIX_TABLE_TOP_ASSERT_SVH
`define EUCLIDEAN_DISTANCE_MATRIX_TABLE_TOP_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define EDM_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define EDM_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* rtl/core/edm_pkg.sv */
// shared types and constants for the distance matrix table
// no dependencies
`default_nettype none
package edm_pkg;
    localparam int MAX_CITIES_DEF  = 64;
    localparam int COORD_WIDTH_DEF = 24;
    localparam int IDX_W   = $clog2(MAX_CITIES_DEF);
    localparam int NUM_W   = $clog2(MAX_CITIES_DEF + 1);
    localparam int DIST_W  = COORD_WIDTH_DEF + 1;
    localparam int CIN_W   = COORD_WIDTH_DEF;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [1:0] {
        REQ_SEARCH = 2'd0,
        REQ_EDIT   = 2'd1,
        REQ_INSERT = 2'd2,
        REQ_REMOVE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_IDX  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [IDX_W-1:0]  src_index;
        logic [IDX_W-1:0]  dest_index;
        logic [DIST_W-1:0] edge_value;
        logic [CIN_W-1:0]  coord_x;
        logic [CIN_W-1:0]  coord_y;
        logic [NUM_W-1:0]  city_number;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0] dist_out;
        logic [NUM_W-1:0]  city_count;
        logic [STAT_W-1:0] status;
    } t_out_item;
endpackage
`default_nettype wire

/* rtl/core/edm_if.sv */
// valid/ready channel interface carrying one item payload
// depends on nothing but the payload type parameter
`default_nettype none
interface edm_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/euclidean_distance_matrix_table_top.sv */
// distance matrix table: edit and bad requests give their item in the cycle after
// acceptance, search after its read and search states, insert after one square
// root per existing city, remove after matrix compaction through one memory
// port (address, read, write for each moved entry)
// one item at a time; the next item waits at the input until the result is taken
// reset clears the city count, state and output valid; memories are undefined until written
`default_nettype none
module euclidean_distance_matrix_table_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    edm_if.sink       i_req,
    edm_if.source     o_rsp
);
    import edm_pkg::*;
    localparam int MAX_CITIES  = MAX_CITIES_DEF;
    localparam int COORD_WIDTH = COORD_WIDTH_DEF;
    localparam int AW  = $clog2(MAX_CITIES);
    localparam int CNW = $clog2(MAX_CITIES + 1);
    localparam int SQW = 2 * COORD_WIDTH + 2;
    localparam int SQE = SQW + (SQW % 2);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD    = 9'b000000010,
        S_SRCH  = 9'b000000100,
        S_CRD   = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_SQ    = 9'b000100000,
        S_WR2   = 9'b001000000,
        S_MVRD  = 9'b010000000,
        S_MVWR  = 9'b100000000
    } t_state;

    // memories
    logic [DIST_W-1:0]        r_dist [MAX_CITIES*MAX_CITIES];
    logic [2*COORD_WIDTH-1:0] r_crd  [MAX_CITIES];
    logic [DIST_W-1:0]        r_drd;
    logic [2*COORD_WIDTH-1:0] r_crdq;
    logic                     r_dwe, r_cwe;
    logic [2*AW-1:0]          r_dwa, r_dra;
    logic [DIST_W-1:0]        r_dwd;
    logic [AW-1:0]            r_cwa, r_cra;
    logic [2*COORD_WIDTH-1:0] r_cwd;

    t_state            r_st;
    logic [CNW-1:0]    r_cnt;
    logic [CNW-1:0]    r_i, r_j, r_rm;
    logic              r_pass;       // remove: 0 rows, 1 columns
    logic [COORD_WIDTH-1:0] r_nx, r_ny;
    logic signed [COORD_WIDTH:0] r_dx, r_dy;
    logic [SQW-1:0]    r_sq;
    logic              r_sq_go;
    logic              w_sq_done;
    logic [SQE/2-1:0]  w_root;
    logic              r_ov;
    t_out_item         r_out;
    logic              r_oval;

    always_ff @(posedge i_clk) begin
        if (r_dwe) r_dist[r_dwa] <= r_dwd;
        r_drd <= r_dist[r_dra];
        if (r_cwe) r_crd[r_cwa] <= r_cwd;
        r_crdq <= r_crd[r_cra];
    end

    edm_isqrt #(.IN_W(SQE)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_sq_go),
        .i_radicand(SQE'(r_sq)), .o_done(w_sq_done), .o_root(w_root));

    assign i_req.ready = (r_st == S_IDLE) && !r_oval;
    assign o_rsp.valid = r_oval;
    assign o_rsp.data  = r_out;

    logic w_acc;
    assign w_acc = i_req.valid && i_req.ready;

    logic [CNW-1:0] w_src, w_dst, w_num;
    assign w_src = CNW'(i_req.data.src_index);
    assign w_dst = CNW'(i_req.data.dest_index);
    assign w_num = CNW'(i_req.data.city_number);

    logic w_sidx_bad, w_num_bad;
    assign w_sidx_bad = (32'(i_req.data.src_index) >= 32'(r_cnt))
        || (32'(i_req.data.dest_index) >= 32'(r_cnt))
        || (32'(i_req.data.src_index) >= 32'(MAX_CITIES))
        || (32'(i_req.data.dest_index) >= 32'(MAX_CITIES));
    assign w_num_bad = (i_req.data.city_number == '0)
        || (32'(i_req.data.city_number) > 32'(r_cnt));

    logic signed [COORD_WIDTH:0] w_ox, w_oy;
    assign w_ox = $signed({r_crdq[2*COORD_WIDTH-1], r_crdq[2*COORD_WIDTH-1 -: COORD_WIDTH]});
    assign w_oy = $signed({r_crdq[COORD_WIDTH-1], r_crdq[COORD_WIDTH-1:0]});

    // magnitudes of the differences, products at full width
    logic [COORD_WIDTH:0] w_ax, w_ay;
    assign w_ax = r_dx[COORD_WIDTH] ? $unsigned(-r_dx) : $unsigned(r_dx);
    assign w_ay = r_dy[COORD_WIDTH] ? $unsigned(-r_dy) : $unsigned(r_dy);

    logic [SQW-1:0] w_px, w_py;
    assign w_px = w_ax * w_ax;
    assign w_py = w_ay * w_ay;

    // remove addresses: rows pass copies (i+1,j)->(i,j); columns (i,j+1)->(i,j)
    logic [2*AW-1:0] w_mv_src, w_mv_dst;
    assign w_mv_dst = {AW'(r_i), AW'(r_j)};
    assign w_mv_src = r_pass ? {AW'(r_i), AW'(r_j + 1'b1)} : {AW'(r_i + 1'b1), AW'(r_j)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_cnt   <= '0;
            r_oval  <= 1'b0;
            r_dwe   <= 1'b0;
            r_cwe   <= 1'b0;
            r_sq_go <= 1'b0;
        end else begin
            r_dwe   <= 1'b0;
            r_cwe   <= 1'b0;
            r_sq_go <= 1'b0;
            if (o_rsp.valid && o_rsp.ready) r_oval <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (w_acc) begin
                        r_out.dist_out <= '0;
                        r_out.status   <= ST_OK;
                        case (t_req'(i_req.data.req_type))
                            REQ_SEARCH, REQ_EDIT: begin
                                if (w_sidx_bad) begin
                                    r_out.status     <= ST_IDX;
                                    r_out.city_count <= NUM_W'(r_cnt);
                                    r_oval           <= 1'b1;
                                end else if (i_req.data.req_type == REQ_EDIT) begin
                                    r_dwe <= 1'b1;
                                    r_dwa <= {AW'(w_src), AW'(w_dst)};
                                    r_dwd <= i_req.data.edge_value;
                                    r_out.city_count <= NUM_W'(r_cnt);
                                    r_oval <= 1'b1;
                                end else begin
                                    r_dra <= {AW'(w_src), AW'(w_dst)};
                                    r_st  <= S_RD;
                                end
                            end
                            REQ_INSERT: begin
                                if (32'(r_cnt) >= 32'(MAX_CITIES)) begin
                                    r_out.status     <= ST_FULL;
                                    r_out.city_count <= NUM_W'(r_cnt);
                                    r_oval           <= 1'b1;
                                end else begin
                                    r_nx  <= i_req.data.coord_x[COORD_WIDTH-1:0];
                                    r_ny  <= i_req.data.coord_y[COORD_WIDTH-1:0];
                                    r_cwe <= 1'b1;
                                    r_cwa <= AW'(r_cnt);
                                    r_cwd <= {i_req.data.coord_x[COORD_WIDTH-1:0],
                                              i_req.data.coord_y[COORD_WIDTH-1:0]};
                                    // diagonal entry
                                    r_dwe <= 1'b1;
                                    r_dwa <= {AW'(r_cnt), AW'(r_cnt)};
                                    r_dwd <= '0;
                                    r_i   <= '0;
                                    r_cra <= '0;
                                    r_st  <= S_CRD;
                                end
                            end
                            default: begin
                                if (w_num_bad) begin
                                    r_out.status     <= ST_IDX;
                                    r_out.city_count <= NUM_W'(r_cnt);
                                    r_oval           <= 1'b1;
                                end else begin
                                    r_rm   <= w_num - 1'b1;
                                    r_i    <= w_num - 1'b1;
                                    r_j    <= '0;
                                    r_pass <= 1'b0;
                                    r_st   <= S_MVRD;
                                end
                            end
                        endcase
                    end
                end
                S_RD: r_st <= S_SRCH;
                S_SRCH: begin
                    r_out.dist_out   <= r_drd;
                    r_out.city_count <= NUM_W'(r_cnt);
                    r_oval           <= 1'b1;
                    r_st             <= S_IDLE;
                end
                S_CRD: begin
                    // coordinate of city r_i is being read
                    if (r_i == r_cnt) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_out.city_count <= NUM_W'(r_cnt + 1'b1);
                        r_oval <= 1'b1;
                        r_st   <= S_IDLE;
                    end else begin
                        r_st <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_dx <= $signed({r_nx[COORD_WIDTH-1], r_nx}) - w_ox;
                    r_dy <= $signed({r_ny[COORD_WIDTH-1], r_ny}) - w_oy;
                    r_st <= S_SQ;
                    r_ov <= 1'b0;
                end
                S_SQ: begin
                    if (!r_ov) begin
                        r_sq    <= w_px + w_py;
                        r_sq_go <= 1'b1;
                        r_ov    <= 1'b1;
                    end else if (w_sq_done) begin
                        r_dwe <= 1'b1;
                        r_dwa <= {AW'(r_cnt), AW'(r_i)};
                        r_dwd <= (32'(w_root) > 32'(DIST_MAX)) ? DIST_MAX
                                 : DIST_W'(w_root);
                        r_st  <= S_WR2;
                    end
                end
                S_WR2: begin
                    r_dwe <= 1'b1;
                    r_dwa <= {AW'(r_i), AW'(r_cnt)};
                    r_i   <= r_i + 1'b1;
                    r_cra <= AW'(r_i + 1'b1);
                    r_st  <= S_CRD;
                end
                S_MVRD: begin
                    // end checks for each pass
                    if (!r_pass && r_i + 1'b1 >= r_cnt) begin
                        r_pass <= 1'b1;
                        r_i    <= '0;
                        r_j    <= r_rm;
                    end else if (r_pass && (r_i + 1'b1 >= r_cnt)) begin
                        r_cnt <= r_cnt - 1'b1;
                        r_out.city_count <= NUM_W'(r_cnt - 1'b1);
                        r_oval <= 1'b1;
                        r_st   <= S_IDLE;
                    end else if (r_pass && (r_j + 1'b1 >= r_cnt)) begin
                        r_i <= r_i + 1'b1;
                        r_j <= r_rm;
                    end else begin
                        r_dra <= w_mv_src;
                        if (!r_pass && r_j == '0) r_cra <= AW'(r_i + 1'b1);
                        r_st  <= S_MVWR;
                        r_ov  <= 1'b0;
                    end
                end
                S_MVWR: begin
                    if (!r_ov) begin
                        r_ov <= 1'b1;
                    end else begin
                        r_dwe <= 1'b1;
                        r_dwa <= w_mv_dst;
                        r_dwd <= r_drd;
                        if (!r_pass && r_j == '0) begin
                            r_cwe <= 1'b1;
                            r_cwa <= AW'(r_i);
                            r_cwd <= r_crdq;
                        end
                        if (!r_pass && r_j + 1'b1 >= r_cnt) begin
                            r_j <= '0;
                            r_i <= r_i + 1'b1;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                        r_st <= S_MVRD;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `include "euclidean_distance_matrix_table_top_assert.svh"
    `EDM_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, 32'(r_cnt) <= 32'(MAX_CITIES))
    `EDM_ASSERT_IMP(a_busy_no_ready, i_clk, i_rst_n, r_st != S_IDLE, !i_req.ready)
    `EDM_ASSERT_NXT(a_sq_once, i_clk, i_rst_n, r_sq_go, !r_sq_go)
endmodule
`default_nettype wire

/* rtl/core/edm_isqrt.sv */
// iterative integer square root, one root bit per step from two radicand bits; a start while busy restarts it
// depends on edm_pkg
`default_nettype none
module edm_isqrt #(
    parameter int IN_W = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [IN_W-1:0]      i_radicand,
    output logic                      o_done,
    output logic [IN_W/2-1:0]         o_root
);
    import edm_pkg::*;
    localparam int RW = IN_W / 2;
    localparam int CW = $clog2(RW / 2 + 1) + 1;
    logic [IN_W-1:0] r_rem, r_src;
    logic [RW-1:0]   r_root;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic [RW+1:0]   w_trial, w_remhi;
    logic [RW+1:0]   w_rcat;

    always_comb begin
        w_rcat  = {r_rem[RW-1:0], r_src[IN_W-1 -: 2]};
        w_trial = {r_root, 2'b01};
        w_remhi = w_rcat - w_trial;
    end

    // each step: rem = rem*4 + next two bits, compare with 4*root+1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_src  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CW'(RW);
            end else if (r_busy) begin
                if (w_rcat >= w_trial) begin
                    r_rem  <= IN_W'(w_remhi);
                    r_root <= {r_root[RW-2:0], 1'b1};
                end else begin
                    r_rem  <= IN_W'(w_rcat);
                    r_root <= {r_root[RW-2:0], 1'b0};
                end
                r_src <= {r_src[IN_W-3:0], 2'b00};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_root = r_root;
endmodule
`default_nettype wire
